[rtl/rcppm_pkg.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder / servo command package
// Shared constants, register indexes, command kinds and the config struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rcppm_pkg;

	// Payload widths fixed by the item format
	localparam int OP_W   = 2;
	localparam int CH_W   = 3;
	localparam int VAL_W  = 16;
	localparam int REG_W  = 3;

	// Defaults for the top level parameters
	localparam int NUM_CHANNELS_DEF = 8;
	localparam int PPM_SLOTS_DEF    = 7;
	localparam int QUEUE_DEPTH      = 2;

	// Divider geometry for the servo read: (period - duty) << 8 over a Q8 scale
	localparam int DIV_DW = VAL_W + 8;
	localparam int DIV_VW = VAL_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CAPTURE    = 2'd0;
	localparam logic [OP_W-1:0] OP_SERVO_WR   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ_INPUT = 2'd2;
	localparam logic [OP_W-1:0] OP_READ_SERVO = 2'd3;

	// Register indexes
	localparam logic [REG_W-1:0] REG_PPM_MODE   = 3'd0;
	localparam logic [REG_W-1:0] REG_SYNC_THR   = 3'd1;
	localparam logic [REG_W-1:0] REG_MIN_US     = 3'd2;
	localparam logic [REG_W-1:0] REG_MAX_US     = 3'd3;
	localparam logic [REG_W-1:0] REG_PERIOD     = 3'd4;
	localparam logic [REG_W-1:0] REG_TPU_Q8     = 3'd5;
	localparam logic [REG_W-1:0] REG_UPT_Q16    = 3'd6;
	localparam logic [REG_W-1:0] REG_PPM_OFFSET = 3'd7;

	// Register reset values
	localparam logic [VAL_W-1:0] RST_SYNC_THR   = 16'd11250;
	localparam logic [VAL_W-1:0] RST_MIN_US     = 16'd1000;
	localparam logic [VAL_W-1:0] RST_MAX_US     = 16'd2000;
	localparam logic [VAL_W-1:0] RST_PERIOD     = 16'd22500;
	localparam logic [VAL_W-1:0] RST_TPU_Q8     = 16'd576;
	localparam logic [VAL_W-1:0] RST_UPT_Q16    = 16'd29125;
	localparam logic [VAL_W-1:0] RST_PPM_OFFSET = 16'd400;
	localparam logic [VAL_W-1:0] DUTY_RESET     = 16'd19125;

	// Decoded command kinds passed from front to back
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] K_NONE      = 3'd0;
	localparam logic [KIND_W-1:0] K_STORE_US  = 3'd1;
	localparam logic [KIND_W-1:0] K_STORE_PPM = 3'd2;
	localparam logic [KIND_W-1:0] K_SERVO_WR  = 3'd3;
	localparam logic [KIND_W-1:0] K_RD_INPUT  = 3'd4;
	localparam logic [KIND_W-1:0] K_RD_SERVO  = 3'd5;

	typedef struct packed {
		logic             ppm_mode;
		logic [VAL_W-1:0] sync_thr;
		logic [VAL_W-1:0] min_us;
		logic [VAL_W-1:0] max_us;
		logic [VAL_W-1:0] period;
		logic [VAL_W-1:0] tpu_q8;
		logic [VAL_W-1:0] upt_q16;
		logic [VAL_W-1:0] ppm_offset;
	} cfg_t;

	// A 3-bit channel clamps to at most 7, so no more than 8 entries are reachable
	function automatic int num_stored(input int num_ch);
		return (num_ch < 8) ? num_ch : 8;
	endfunction

	function automatic int idx_width(input int num_ch);
		return (num_stored(num_ch) > 1) ? $clog2(num_stored(num_ch)) : 1;
	endfunction

	function automatic int slot_width(input int slots);
		return (slots > 1) ? $clog2(slots) : 1;
	endfunction

	function automatic int entry_width(input int num_ch);
		return KIND_W + idx_width(num_ch) + VAL_W;
	endfunction

endpackage

`default_nettype wire

[rtl/rcppm_ifs.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder / servo command channel interfaces
// Valid/ready channels for commands, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcppm_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [rcppm_pkg::OP_W-1:0]  operation;
	logic [rcppm_pkg::CH_W-1:0]  channel;
	logic [rcppm_pkg::VAL_W-1:0] value;

	modport source (output valid, output operation, output channel, output value,
		input ready);
	modport sink (input valid, input operation, input channel, input value,
		output ready);
endinterface

interface rcppm_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [rcppm_pkg::VAL_W-1:0] read_data;

	modport source (output valid, output read_data, input ready);
	modport sink (input valid, input read_data, output ready);
endinterface

interface rcppm_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [rcppm_pkg::REG_W-1:0] index;
	logic [rcppm_pkg::VAL_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/rcppm_front.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder front end
// Accepts commands, clamps the channel, runs the PPM frame decoder and
// pushes one decoded command per transaction into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rcppm_front #(
	parameter int NUM_CHANNELS = rcppm_pkg::NUM_CHANNELS_DEF,
	parameter int PPM_SLOTS    = rcppm_pkg::PPM_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	rcppm_cmd_if.sink                cmd,
	input  wire rcppm_pkg::cfg_t     cfg,
	input  wire logic                full,
	output logic                     push,
	output logic [rcppm_pkg::entry_width(NUM_CHANNELS)-1:0] entry
);
	import rcppm_pkg::*;

	localparam int IDX_W  = idx_width(NUM_CHANNELS);
	localparam int SLOT_W = slot_width(PPM_SLOTS);

	logic              synced_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CH_W-1:0]   ch_cl;
	logic              is_ppm;
	logic              is_sync;
	logic              slot_last;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  idx;

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	assign ch_cl = (int'(cmd.channel) >= NUM_CHANNELS) ? CH_W'(NUM_CHANNELS - 1)
		: cmd.channel;
	assign is_ppm    = (cmd.operation == OP_CAPTURE) && cfg.ppm_mode && (ch_cl == '0);
	assign is_sync   = cmd.value > cfg.sync_thr;
	assign slot_last = slot_q == SLOT_W'(PPM_SLOTS - 1);

	always_comb begin
		idx  = IDX_W'(ch_cl);
		kind = K_NONE;
		case (cmd.operation)
			OP_CAPTURE: begin
				if (!is_ppm) begin
					kind = K_STORE_US;
				end else if (!is_sync && synced_q && (int'(slot_q) < NUM_CHANNELS)) begin
					kind = K_STORE_PPM;
					idx  = IDX_W'(slot_q);
				end
			end
			OP_SERVO_WR:   kind = K_SERVO_WR;
			OP_READ_INPUT: kind = K_RD_INPUT;
			OP_READ_SERVO: kind = K_RD_SERVO;
			default:       kind = K_NONE;
		endcase
	end

	assign entry = {kind, idx, cmd.value};

	// Frame decoder: sync restarts at slot 0, last slot drops sync
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			slot_q   <= '0;
		end else if (push && is_ppm) begin
			if (is_sync) begin
				synced_q <= 1'b1;
				slot_q   <= '0;
			end else if (synced_q) begin
				if (slot_last) begin
					synced_q <= 1'b0;
					slot_q   <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !synced_q |-> slot_q == '0)
		else $error("slot index nonzero outside a frame");

endmodule

`default_nettype wire

[rtl/rcppm_fifo.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcppm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = rcppm_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == CNT_W'($past(count_q) + 1'b1))
		else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

[rtl/rcppm_div.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcppm_div #(
	parameter int DW = rcppm_pkg::DIV_DW,
	parameter int VW = rcppm_pkg::DIV_VW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [VW-1:0]    dvs_q;
	logic [VW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic             fits;

	assign trial    = {rem_q, dvd_q[DW-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = dvd_q;

	// Quotient bits shift into the vacated low end of the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/rcppm_back.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder back end
// Executes decoded commands on the input and duty register files, with one
// shared multiplier stage, a divider for servo reads and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcppm_back #(
	parameter int NUM_CHANNELS = rcppm_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rcppm_pkg::cfg_t     cfg,
	input  wire logic [rcppm_pkg::entry_width(NUM_CHANNELS)-1:0] entry,
	input  wire logic                empty,
	output logic                     pop,
	rcppm_rsp_if.source              rsp
);
	import rcppm_pkg::*;

	localparam int IDX_W  = idx_width(NUM_CHANNELS);
	localparam int NSTORE = num_stored(NUM_CHANNELS);
	localparam int EW     = entry_width(NUM_CHANNELS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]          state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [IDX_W-1:0]    idx_q;
	logic [VAL_W-1:0]    mul_a_q;
	logic [VAL_W-1:0]    mul_b_q;
	logic [2*VAL_W-1:0]  prod_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    rd_q;
	logic [VAL_W-1:0]    input_values_q [NSTORE];
	logic [VAL_W-1:0]    servo_duty_q [NSTORE];

	logic [KIND_W-1:0]   e_kind;
	logic [IDX_W-1:0]    e_idx;
	logic [VAL_W-1:0]    e_val;
	logic [VAL_W-1:0]    us_hi;
	logic [VAL_W-1:0]    us_cl;
	logic [VAL_W-1:0]    us_scaled;
	logic [VAL_W:0]      ppm_sum;
	logic [VAL_W-1:0]    ppm_us;
	logic [DIV_DW-1:0]   ticks;
	logic [VAL_W-1:0]    duty_new;
	logic [VAL_W-1:0]    duty_rd;
	logic                rd_bad;
	logic [VAL_W-1:0]    span;
	logic                div_start;
	logic                div_done;
	logic [DIV_DW-1:0]   div_quo;
	logic [VAL_W-1:0]    quo_sat;

	assign e_kind = entry[EW-1 -: KIND_W];
	assign e_idx  = entry[VAL_W +: IDX_W];
	assign e_val  = entry[VAL_W-1:0];

	assign pop = (state_q == ST_IDLE) && !empty && !out_valid_q;

	// Max clamp first, so inverted limits resolve to the minimum
	assign us_hi = (e_val > cfg.max_us) ? cfg.max_us : e_val;
	assign us_cl = (us_hi < cfg.min_us) ? cfg.min_us : us_hi;

	assign us_scaled = prod_q[2*VAL_W-1:VAL_W];
	assign ppm_sum   = {1'b0, us_scaled} + {1'b0, cfg.ppm_offset};
	assign ppm_us    = ppm_sum[VAL_W] ? '1 : ppm_sum[VAL_W-1:0];

	assign ticks    = prod_q[2*VAL_W-1:8];
	assign duty_new = (ticks > DIV_DW'(cfg.period)) ? '0 : cfg.period - ticks[VAL_W-1:0];

	assign duty_rd   = servo_duty_q[idx_q];
	assign rd_bad    = (duty_rd > cfg.period) || (cfg.tpu_q8 == '0);
	assign span      = cfg.period - duty_rd;
	assign div_start = (state_q == ST_WB) && (kind_q == K_RD_SERVO) && !rd_bad;
	assign quo_sat   = (div_quo[DIV_DW-1:VAL_W] != '0) ? '1 : div_quo[VAL_W-1:0];

	rcppm_div #(
		.DW (DIV_DW),
		.VW (DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({span, 8'd0}),
		.divisor  (cfg.tpu_q8),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = rd_q;

	// Operand and product registers
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= e_kind;
			idx_q   <= e_idx;
			mul_a_q <= (e_kind == K_SERVO_WR) ? us_cl : e_val;
			mul_b_q <= (e_kind == K_SERVO_WR) ? cfg.tpu_q8 : cfg.upt_q16;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a_q * mul_b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			rd_q        <= '0;
			for (int i = 0; i < NSTORE; i++) begin
				input_values_q[i] <= '0;
				servo_duty_q[i]   <= DUTY_RESET;
			end
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= (e_kind == K_STORE_US || e_kind == K_STORE_PPM ||
							e_kind == K_SERVO_WR) ? ST_MUL : ST_WB;
					end
				end
				ST_MUL: state_q <= ST_WB;
				ST_WB: begin
					// a valid servo read waits for the divider
					state_q     <= div_start ? ST_DIV : ST_IDLE;
					out_valid_q <= !div_start;
					rd_q        <= (kind_q == K_RD_INPUT) ? input_values_q[idx_q] : '0;
					case (kind_q)
						K_STORE_US:  input_values_q[idx_q] <= us_scaled;
						K_STORE_PPM: input_values_q[idx_q] <= ppm_us;
						K_SERVO_WR:  servo_duty_q[idx_q]   <= duty_new;
						default: ;
					endcase
				end
				ST_DIV: begin
					if (div_done) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						rd_q        <= quo_sat;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_DIV |-> !out_valid_q)
		else $error("result pending while a servo read divides");
	assert property (@(posedge clk) disable iff (!arst_n) div_done |-> state_q == ST_DIV)
		else $error("divider finished with no servo read waiting");

endmodule

`default_nettype wire

[rtl/rc_ppm_decode_servo_command.sv]
// ----------------------------------------------------------------------------
// RC PPM decoder and servo command block
// Capture scaling, PPM frame decoding, servo duty storage and readback.
// ----------------------------------------------------------------------------
// One result transaction follows every command transaction, in order. The
// front end takes a command each cycle while its two-entry queue has room;
// the back end works one command at a time: a stored capture or servo write
// passes through operand, multiply and write back, an input read through
// operand and write back, and a servo read through operand, write back and
// the bit-serial divider that converts duty back to microseconds. The back
// end starts the next command once the previous result has been taken.
// Configuration writes are always ready and are meant for idle periods only.
`default_nettype none

module rc_ppm_decode_servo_command #(
	parameter int NUM_CHANNELS = rcppm_pkg::NUM_CHANNELS_DEF,
	parameter int PPM_SLOTS    = rcppm_pkg::PPM_SLOTS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rcppm_cmd_if.sink   cmd,
	rcppm_rsp_if.source rsp,
	rcppm_cfg_if.sink   cfg
);
	import rcppm_pkg::*;

	localparam int EW = entry_width(NUM_CHANNELS);

	cfg_t          cfg_q;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	logic [EW-1:0] wentry;
	logic [EW-1:0] rentry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ppm_mode   <= 1'b1;
			cfg_q.sync_thr   <= RST_SYNC_THR;
			cfg_q.min_us     <= RST_MIN_US;
			cfg_q.max_us     <= RST_MAX_US;
			cfg_q.period     <= RST_PERIOD;
			cfg_q.tpu_q8     <= RST_TPU_Q8;
			cfg_q.upt_q16    <= RST_UPT_Q16;
			cfg_q.ppm_offset <= RST_PPM_OFFSET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PPM_MODE:   cfg_q.ppm_mode   <= cfg.data[0];
				REG_SYNC_THR:   cfg_q.sync_thr   <= cfg.data;
				REG_MIN_US:     cfg_q.min_us     <= cfg.data;
				REG_MAX_US:     cfg_q.max_us     <= cfg.data;
				REG_PERIOD:     cfg_q.period     <= cfg.data;
				REG_TPU_Q8:     cfg_q.tpu_q8     <= cfg.data;
				REG_UPT_Q16:    cfg_q.upt_q16    <= cfg.data;
				REG_PPM_OFFSET: cfg_q.ppm_offset <= cfg.data;
				default: ;
			endcase
		end
	end

	rcppm_front #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.PPM_SLOTS    (PPM_SLOTS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg_q),
		.full   (full),
		.push   (push),
		.entry  (wentry)
	);

	rcppm_fifo #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.pop    (pop),
		.rdata  (rentry),
		.full   (full),
		.empty  (empty)
	);

	rcppm_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.entry  (rentry),
		.empty  (empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC PPM decoder / servo command testbench
// Drives capture, servo write and readback commands with random idles and
// back pressure. A shadow copy of the channel registers, the PPM frame state
// and the settings predicts each read_data, which is checked in order.
// ----------------------------------------------------------------------------

module testbench;
	import rcppm_pkg::*;

	localparam int CHANNELS        = 8;
	localparam int SLOTS           = 7;
	localparam int IDLE_PCT        = 38;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int STEADY_PHASE    = 3;
	localparam int HOLD_PHASE      = 6;

	typedef enum int {
		SET_RESET,
		SET_RANDOM,
		SET_ALL_MAX,
		SET_ALL_ZERO,
		SET_CORNER
	} setting_kind_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CH_W-1:0]  ch;
		logic [VAL_W-1:0] val;
	} servo_cmd_t;

	logic clk = 1'b0;
	logic arst_n;

	rcppm_cmd_if cmd_ch();
	rcppm_rsp_if rsp_ch();
	rcppm_cfg_if cfg_ch();

	rc_ppm_decode_servo_command dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	servo_cmd_t       pending_cmds[$];
	logic [VAL_W-1:0] expected_reads[$];
	int               errors = 0;
	int               stalled = 0;
	logic             steady = 1'b0;
	logic             hold_req = 1'b0;
	logic             hold_taken;
	int               hold_cnt;

	// shadow of the block state
	cfg_t             shadow_cfg;
	logic [VAL_W-1:0] in_regs[CHANNELS];
	logic [VAL_W-1:0] duty_regs[CHANNELS];
	logic             frame_synced;
	int               slot_idx;

	function automatic cfg_t reset_settings();
		return '{1'b1, RST_SYNC_THR, RST_MIN_US, RST_MAX_US, RST_PERIOD, RST_TPU_Q8,
			RST_UPT_Q16, RST_PPM_OFFSET};
	endfunction

	function automatic logic [VAL_W-1:0] ticks_to_us(logic [VAL_W-1:0] ticks);
		logic [31:0] prod;
		prod = ticks * shadow_cfg.upt_q16;
		return prod[31:16];
	endfunction

	// Advances the shadow state by one command and returns its read_data.
	// A 3-bit channel never exceeds CHANNELS-1, so the channel clamp is a no-op.
	function automatic logic [VAL_W-1:0] predict_read(servo_cmd_t c);
		logic [VAL_W-1:0] us;
		logic [16:0]      sum;
		logic [31:0]      ticks;
		logic [23:0]      quot;
		logic [VAL_W-1:0] duty;
		predict_read = '0;
		case (c.op)
			OP_CAPTURE: begin
				us = ticks_to_us(c.val);
				if (shadow_cfg.ppm_mode && c.ch == 0) begin
					if (c.val > shadow_cfg.sync_thr) begin
						frame_synced = 1'b1;
						slot_idx = 0;
					end else if (frame_synced) begin
						sum = us + shadow_cfg.ppm_offset;
						if (slot_idx < CHANNELS)
							in_regs[slot_idx] = sum[16] ? '1 : sum[15:0];
						slot_idx++;
						if (slot_idx >= SLOTS) begin
							frame_synced = 1'b0;
							slot_idx = 0;
						end
					end
				end else begin
					in_regs[c.ch] = us;
				end
			end
			OP_SERVO_WR: begin
				us = c.val;
				// max first, so inverted clamps end at min
				if (us > shadow_cfg.max_us)
					us = shadow_cfg.max_us;
				if (us < shadow_cfg.min_us)
					us = shadow_cfg.min_us;
				ticks = us * shadow_cfg.tpu_q8;
				ticks = ticks >> 8;
				duty_regs[c.ch] = (ticks > shadow_cfg.period) ? '0
					: shadow_cfg.period - ticks[15:0];
			end
			OP_READ_INPUT: begin
				predict_read = in_regs[c.ch];
			end
			default: begin
				duty = duty_regs[c.ch];
				if (duty <= shadow_cfg.period && shadow_cfg.tpu_q8 != 0) begin
					quot = {shadow_cfg.period - duty, 8'h00} / shadow_cfg.tpu_q8;
					predict_read = (quot > 24'hFFFF) ? '1 : quot[15:0];
				end
			end
		endcase
	endfunction

	function automatic void apply_reg(logic [REG_W-1:0] idx, logic [VAL_W-1:0] d);
		case (idx)
			REG_PPM_MODE:   shadow_cfg.ppm_mode = d[0];
			REG_SYNC_THR:   shadow_cfg.sync_thr = d;
			REG_MIN_US:     shadow_cfg.min_us = d;
			REG_MAX_US:     shadow_cfg.max_us = d;
			REG_PERIOD:     shadow_cfg.period = d;
			REG_TPU_Q8:     shadow_cfg.tpu_q8 = d;
			REG_UPT_Q16:    shadow_cfg.upt_q16 = d;
			REG_PPM_OFFSET: shadow_cfg.ppm_offset = d;
			default: ;
		endcase
	endfunction

	task automatic write_reg(logic [REG_W-1:0] idx, logic [VAL_W-1:0] d);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		apply_reg(idx, d);
	endtask

	function automatic logic [VAL_W-1:0] pick_value(logic [VAL_W-1:0] rst);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return rst;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic apply_setting(setting_kind_t kind);
		cfg_t nxt;
		case (kind)
			SET_RESET:    nxt = reset_settings();
			SET_ALL_MAX:  nxt = '1;
			SET_ALL_ZERO: nxt = '0;
			SET_CORNER: begin
				// inverted clamps, pulse longer than a short period
				nxt = reset_settings();
				nxt.min_us = 16'd3000;
				nxt.max_us = 16'd500;
				nxt.period = 16'd100;
				nxt.tpu_q8 = '1;
			end
			default: begin
				nxt.ppm_mode   = 1'($urandom);
				nxt.sync_thr   = pick_value(RST_SYNC_THR);
				nxt.min_us     = pick_value(RST_MIN_US);
				nxt.max_us     = pick_value(RST_MAX_US);
				nxt.period     = pick_value(RST_PERIOD);
				nxt.tpu_q8     = pick_value(RST_TPU_Q8);
				nxt.upt_q16    = pick_value(RST_UPT_Q16);
				nxt.ppm_offset = pick_value(RST_PPM_OFFSET);
			end
		endcase
		// only bit 0 of the mode register counts
		write_reg(REG_PPM_MODE, {15'($urandom), nxt.ppm_mode});
		write_reg(REG_SYNC_THR, nxt.sync_thr);
		write_reg(REG_MIN_US, nxt.min_us);
		write_reg(REG_MAX_US, nxt.max_us);
		write_reg(REG_PERIOD, nxt.period);
		write_reg(REG_TPU_Q8, nxt.tpu_q8);
		write_reg(REG_UPT_Q16, nxt.upt_q16);
		write_reg(REG_PPM_OFFSET, nxt.ppm_offset);
	endtask

	function automatic void queue_cmd(logic [OP_W-1:0] op, int ch,
		logic [VAL_W-1:0] val);
		pending_cmds.push_back('{op, CH_W'(ch), val});
	endfunction

	function automatic servo_cmd_t random_cmd();
		servo_cmd_t c;
		int lo;
		int hi;
		c.op = OP_W'($urandom_range(OP_CAPTURE, OP_READ_SERVO));
		c.ch = CH_W'($urandom);
		c.val = VAL_W'($urandom);
		if (c.op == OP_SERVO_WR && $urandom_range(0, 1)) begin
			// land near the clamp window half of the time
			lo = (shadow_cfg.min_us < shadow_cfg.max_us) ? shadow_cfg.min_us : shadow_cfg.max_us;
			hi = (shadow_cfg.min_us < shadow_cfg.max_us) ? shadow_cfg.max_us : shadow_cfg.min_us;
			lo = (lo > 200) ? lo - 200 : 0;
			hi = (hi < 65335) ? hi + 200 : 65535;
			c.val = VAL_W'($urandom_range(lo, hi));
		end
		return c;
	endfunction

	task automatic random_items(int n);
		int made;
		int k;
		int thr;
		made = 0;
		thr = shadow_cfg.sync_thr;
		while (made < n) begin
			if (shadow_cfg.ppm_mode && thr < 65535 && $urandom_range(0, 99) < 35) begin
				// sync pulse then one pulse per slot; some frames get cut short
				queue_cmd(OP_CAPTURE, 0, VAL_W'($urandom_range(thr + 1, 65535)));
				made++;
				for (k = 0; k < SLOTS; k++) begin
					if ($urandom_range(0, 29) == 0)
						break;
					if ($urandom_range(0, 9) == 0) begin
						pending_cmds.push_back(random_cmd());
						made++;
					end
					queue_cmd(OP_CAPTURE, 0, ($urandom_range(0, 9) == 0) ? VAL_W'($urandom)
						: VAL_W'($urandom_range(0, thr)));
					made++;
				end
			end else begin
				pending_cmds.push_back(random_cmd());
				made++;
			end
		end
	endtask

	// checked at the falling edge, once every clocked update has settled
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_reads.size() != 0);
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		servo_cmd_t next_cmd;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.operation <= OP_CAPTURE;
			cmd_ch.channel <= '0;
			cmd_ch.value <= '0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				next_cmd = pending_cmds.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.operation <= next_cmd.op;
				cmd_ch.channel <= next_cmd.ch;
				cmd_ch.value <= next_cmd.val;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, taken once on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt <= 0;
			hold_taken <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_cnt <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= (hold_cnt == 0) && (steady || $urandom_range(0, 99) >= IDLE_PCT);
	end

	// monitor: check the result transaction, then predict the command transaction
	always @(posedge clk) begin
		logic [VAL_W-1:0] want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_reads.size() == 0) begin
					errors++;
					$display("%0t: read_data expected none, actual %0d", $time, rsp_ch.read_data);
				end else begin
					want = expected_reads.pop_front();
					if (rsp_ch.read_data !== want) begin
						errors++;
						$display("%0t: read_data expected %0d, actual %0d", $time, want,
							rsp_ch.read_data);
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready)
				expected_reads.push_back(predict_read(
					servo_cmd_t'{cmd_ch.operation, cmd_ch.channel, cmd_ch.value}));
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled >= WATCHDOG_LIMIT) begin
			$display("rc_ppm_decode_servo_command: mismatch");
			$finish;
		end
	end

	initial begin
		setting_kind_t kind;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_PPM_MODE;
		cfg_ch.data = '0;
		shadow_cfg = reset_settings();
		foreach (in_regs[i]) begin
			in_regs[i] = '0;
			duty_regs[i] = DUTY_RESET;
		end
		frame_synced = 1'b0;
		slot_idx = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset settings (PPM mode on)
		queue_cmd(OP_READ_SERVO, 0, '0);
		queue_cmd(OP_READ_INPUT, 7, '1);
		queue_cmd(OP_CAPTURE, 0, 16'd5000);      // not synced: ignored
		queue_cmd(OP_CAPTURE, 0, RST_SYNC_THR);  // equal to threshold: no sync
		queue_cmd(OP_CAPTURE, 0, '1);            // sync
		queue_cmd(OP_CAPTURE, 0, '0);
		queue_cmd(OP_CAPTURE, 0, RST_SYNC_THR + 16'd1);  // sync while synced
		queue_cmd(OP_CAPTURE, 0, '0);
		queue_cmd(OP_CAPTURE, 0, RST_SYNC_THR);
		queue_cmd(OP_CAPTURE, 0, 16'd1);
		queue_cmd(OP_CAPTURE, 0, 16'd4500);
		queue_cmd(OP_CAPTURE, 0, 16'd6000);
		queue_cmd(OP_CAPTURE, 0, 16'd100);
		queue_cmd(OP_CAPTURE, 0, 16'd11000);     // last slot closes the frame
		queue_cmd(OP_CAPTURE, 0, 16'd3000);      // after frame end: ignored
		queue_cmd(OP_READ_INPUT, 0, '0);
		queue_cmd(OP_READ_INPUT, 6, '0);
		queue_cmd(OP_CAPTURE, 5, '1);
		queue_cmd(OP_READ_INPUT, 5, '0);
		queue_cmd(OP_SERVO_WR, 1, '0);
		queue_cmd(OP_SERVO_WR, 2, '1);
		queue_cmd(OP_READ_SERVO, 1, '0);
		queue_cmd(OP_READ_SERVO, 2, '0);
		queue_cmd(OP_SERVO_WR, 7, 16'd1500);
		queue_cmd(OP_READ_SERVO, 7, '0);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:            kind = SET_CORNER;
				1:            kind = SET_ALL_ZERO;
				2:            kind = SET_ALL_MAX;
				STEADY_PHASE: kind = SET_RESET;
				default:      kind = SET_RANDOM;
			endcase
			apply_setting(kind);
			steady <= (p == STEADY_PHASE);
			if (p == HOLD_PHASE)
				hold_req <= 1'b1;
			random_items(ITEMS_PER_PHASE);
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("rc_ppm_decode_servo_command: match");
		else
			$display("rc_ppm_decode_servo_command: mismatch");
		$finish;
	end

endmodule
